@@ sv/swoc_pkg.sv @@
`default_nettype none

package swoc_pkg;

   // one input transaction
   typedef struct packed {
      logic [1:0] mode;
      logic       switch_closed;
      logic       request_value;
   } req_type;

   // one result transaction
   typedef struct packed {
      logic [11:0] span_pulse_us;
      logic [11:0] turn_pulse_us;
      logic [2:0]  phase;
      logic        is_open;
   } rsp_type;

   // configuration register file contents
   typedef struct packed {
      logic [11:0] open_start_us;
      logic [11:0] open_end_us;
      logic [11:0] close_start_us;
      logic [11:0] close_end_us;
      logic [9:0]  opening_ticks;
      logic [9:0]  opening_dead_ticks;
      logic [9:0]  close_timeout_ticks;
   } cfg_type;

   // pulse request: load a new value given by a linear ramp from a to b at t
   typedef struct packed {
      logic        load;
      logic [9:0]  t;
      logic [11:0] a;
      logic [11:0] b;
   } pulse_desc_type;

   // control decision for one transaction
   typedef struct packed {
      logic [2:0]     phase;
      pulse_desc_type span;
      pulse_desc_type turn;
   } step_type;

   // what follows the arithmetic down the pipeline
   typedef struct packed {
      logic [2:0] phase;
      logic       span_load;
      logic       turn_load;
   } tag_type;

   localparam logic [2:0] PH_INITIAL   = 3'd0;
   localparam logic [2:0] PH_OPENING   = 3'd1;
   localparam logic [2:0] PH_OPEN      = 3'd2;
   localparam logic [2:0] PH_CENTERING = 3'd3;
   localparam logic [2:0] PH_CLOSING   = 3'd4;
   localparam logic [2:0] PH_CLOSED    = 3'd5;
   localparam logic [2:0] PH_BROKEN    = 3'd6;

   localparam logic [1:0] TGT_NONE   = 2'd0;
   localparam logic [1:0] TGT_OPEN   = 2'd1;
   localparam logic [1:0] TGT_CLOSED = 2'd2;

   localparam logic [1:0] DIR_ZERO = 2'b00;
   localparam logic [1:0] DIR_POS  = 2'b01;
   localparam logic [1:0] DIR_NEG  = 2'b11;

   localparam logic [1:0] MODE_TICK   = 2'd0;
   localparam logic [1:0] MODE_TARGET = 2'd1;
   localparam logic [1:0] MODE_SCAN   = 2'd2;

   localparam int unsigned CSR_ADDR_W = 5;
   localparam logic [2:0] REG_OPEN_START    = 3'd0;
   localparam logic [2:0] REG_OPEN_END      = 3'd1;
   localparam logic [2:0] REG_CLOSE_START   = 3'd2;
   localparam logic [2:0] REG_CLOSE_END     = 3'd3;
   localparam logic [2:0] REG_OPENING_TICKS = 3'd4;
   localparam logic [2:0] REG_DEAD_TICKS    = 3'd5;
   localparam logic [2:0] REG_CLOSE_TIMEOUT = 3'd6;

   localparam logic [11:0] RST_OPEN_START_US  = 12'd1400;
   localparam logic [11:0] RST_OPEN_END_US    = 12'd1200;
   localparam logic [11:0] RST_CLOSE_START_US = 12'd1500;
   localparam logic [11:0] RST_CLOSE_END_US   = 12'd1600;
   localparam logic [9:0]  RST_OPENING_TICKS  = 10'd170;
   localparam logic [9:0]  RST_DEAD_TICKS     = 10'd80;
   localparam logic [9:0]  RST_CLOSE_TIMEOUT  = 10'd500;

   localparam logic [9:0]  CNT_MAX       = 10'd1023;
   localparam logic [11:0] TURN_MIN_US   = 12'd1200;
   localparam logic [11:0] TURN_MAX_US   = 12'd1800;
   localparam logic [11:0] TURN_RESET_US = 12'd1500;

endpackage

`default_nettype wire

@@ sv/swoc_csr.sv @@
`default_nettype none

module swoc_csr
   import swoc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic [31:0]                prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_index;
   logic       wr_en;

   assign reg_index = paddr[CSR_ADDR_W-1:2];
   assign wr_en     = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_OPEN_START:    cfg_in.open_start_us       = pwdata[11:0];
            REG_OPEN_END:      cfg_in.open_end_us         = pwdata[11:0];
            REG_CLOSE_START:   cfg_in.close_start_us      = pwdata[11:0];
            REG_CLOSE_END:     cfg_in.close_end_us        = pwdata[11:0];
            REG_OPENING_TICKS: cfg_in.opening_ticks       = pwdata[9:0];
            REG_DEAD_TICKS:    cfg_in.opening_dead_ticks  = pwdata[9:0];
            REG_CLOSE_TIMEOUT: cfg_in.close_timeout_ticks = pwdata[9:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_OPEN_START:    prdata = 32'(cfg_ff.open_start_us);
         REG_OPEN_END:      prdata = 32'(cfg_ff.open_end_us);
         REG_CLOSE_START:   prdata = 32'(cfg_ff.close_start_us);
         REG_CLOSE_END:     prdata = 32'(cfg_ff.close_end_us);
         REG_OPENING_TICKS: prdata = 32'(cfg_ff.opening_ticks);
         REG_DEAD_TICKS:    prdata = 32'(cfg_ff.opening_dead_ticks);
         REG_CLOSE_TIMEOUT: prdata = 32'(cfg_ff.close_timeout_ticks);
         default:           prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.open_start_us       <= RST_OPEN_START_US;
         cfg_ff.open_end_us         <= RST_OPEN_END_US;
         cfg_ff.close_start_us      <= RST_CLOSE_START_US;
         cfg_ff.close_end_us        <= RST_CLOSE_END_US;
         cfg_ff.opening_ticks       <= RST_OPENING_TICKS;
         cfg_ff.opening_dead_ticks  <= RST_DEAD_TICKS;
         cfg_ff.close_timeout_ticks <= RST_CLOSE_TIMEOUT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/swoc_ctrl.sv @@
`default_nettype none

module swoc_ctrl
   import swoc_pkg::*;
#(
   parameter int unsigned TURN_RANGE = 128
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    accept,
   input  wire req_type req,
   input  wire cfg_type cfg,
   output step_type     step
);

   localparam logic [7:0] RANGE_C = 8'(TURN_RANGE);
   localparam logic [7:0] MID_C   = 8'(TURN_RANGE / 2);

   logic [2:0]  phase_ff,  phase_in;
   logic [1:0]  target_ff, target_in;
   logic [9:0]  cnt_ff,    cnt_in;
   logic [7:0]  angle_ff,  angle_in;
   logic [1:0]  dir_ff,    dir_in;
   logic [1:0]  saved_ff,  saved_in;
   logic [9:0]  cnt_inc;
   logic [10:0] cnt_twice;

   function automatic pulse_desc_type set_value(input logic [11:0] v);
      pulse_desc_type d;
      d.load = 1'b1;
      d.t    = 10'd0;
      d.a    = v;
      d.b    = v;
      return d;
   endfunction

   function automatic pulse_desc_type set_ramp(input logic [9:0] t, input logic [11:0] a,
                                               input logic [11:0] b);
      pulse_desc_type d;
      d.load = 1'b1;
      d.t    = t;
      d.a    = a;
      d.b    = b;
      return d;
   endfunction

   function automatic pulse_desc_type set_turn(input logic [7:0] angle);
      return set_ramp(10'(angle), TURN_MIN_US, TURN_MAX_US);
   endfunction

   // saturating ramp counter, closing advances it a second time
   assign cnt_inc   = (cnt_ff == CNT_MAX) ? CNT_MAX : cnt_ff + 10'd1;
   assign cnt_twice = {1'b0, cnt_inc} + 11'd1;

   always_comb begin
      phase_in  = phase_ff;
      target_in = target_ff;
      cnt_in    = cnt_ff;
      angle_in  = angle_ff;
      dir_in    = dir_ff;
      saved_in  = saved_ff;
      step      = '0;
      if (accept) begin
         unique case (req.mode)
            MODE_TICK: begin
               unique case (phase_ff)
                  PH_INITIAL: begin
                     if (req.switch_closed) begin
                        phase_in = PH_CLOSED;
                     end else begin
                        phase_in  = PH_CLOSING;
                        step.span = set_value(cfg.close_start_us);
                        cnt_in    = 10'd0;
                     end
                  end
                  PH_OPENING: begin
                     cnt_in    = cnt_inc;
                     step.span = set_ramp(cnt_inc, cfg.open_start_us, cfg.open_end_us);
                     if (target_ff == TGT_CLOSED) begin
                        // switch already closed: keep this tick's ramp value
                        if (req.switch_closed) begin
                           phase_in = PH_CLOSED;
                        end else begin
                           phase_in  = PH_CLOSING;
                           step.span = set_value(cfg.close_start_us);
                           cnt_in    = 10'd0;
                        end
                     end else if (cnt_inc >= cfg.opening_dead_ticks && req.switch_closed) begin
                        phase_in  = PH_BROKEN;
                        step.span = set_value(12'd0);
                        step.turn = set_value(12'd0);
                     end else if (cnt_inc >= cfg.opening_ticks) begin
                        phase_in  = PH_OPEN;
                        step.span = set_value(12'd0);
                     end
                  end
                  PH_OPEN: begin
                     if (target_ff == TGT_CLOSED) begin
                        if (req.switch_closed) begin
                           phase_in = PH_CLOSED;
                        end else begin
                           phase_in  = PH_CENTERING;
                           step.span = set_value(12'd0);
                           step.turn = set_turn(angle_ff);
                        end
                     end else if (dir_ff != DIR_ZERO) begin
                        if (dir_ff == DIR_NEG) begin
                           if (angle_ff == 8'd0) begin
                              dir_in = DIR_POS;
                           end else begin
                              angle_in = angle_ff - 8'd1;
                           end
                        end else begin
                           if (angle_ff >= RANGE_C) begin
                              angle_in = RANGE_C;
                              dir_in   = DIR_NEG;
                           end else begin
                              angle_in = angle_ff + 8'd1;
                           end
                        end
                        step.turn = set_turn(angle_in);
                     end
                  end
                  PH_CENTERING: begin
                     if (target_ff == TGT_OPEN) begin
                        phase_in = PH_OPEN;
                     end else if (angle_ff == MID_C) begin
                        phase_in  = PH_CLOSING;
                        step.span = set_value(cfg.close_start_us);
                        cnt_in    = 10'd0;
                     end else begin
                        angle_in  = (angle_ff > MID_C) ? angle_ff - 8'd1 : angle_ff + 8'd1;
                        step.turn = set_turn(angle_in);
                     end
                  end
                  PH_CLOSING: begin
                     step.span = set_ramp(cnt_inc, cfg.close_start_us, cfg.close_end_us);
                     if (req.switch_closed) begin
                        phase_in  = PH_CLOSED;
                        cnt_in    = cnt_inc;
                        step.span = set_value(12'd0);
                     end else begin
                        cnt_in = cnt_twice[10] ? CNT_MAX : cnt_twice[9:0];
                        // timeout compares the count before clipping
                        if (cnt_twice > {1'b0, cfg.close_timeout_ticks}) begin
                           phase_in  = PH_BROKEN;
                           step.span = set_value(12'd0);
                           step.turn = set_value(12'd0);
                        end
                     end
                  end
                  PH_CLOSED: begin
                     if (target_ff == TGT_OPEN) begin
                        phase_in  = PH_OPENING;
                        step.span = set_value(cfg.open_start_us);
                        cnt_in    = 10'd0;
                     end
                  end
                  default: ;
               endcase
            end
            MODE_TARGET: begin
               target_in = req.request_value ? TGT_OPEN : TGT_CLOSED;
            end
            MODE_SCAN: begin
               if (req.request_value) begin
                  dir_in = (saved_ff == DIR_ZERO) ? DIR_POS : saved_ff;
               end else begin
                  saved_in = dir_ff;
                  dir_in   = DIR_ZERO;
               end
            end
            default: ;
         endcase
      end
      step.phase = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_INITIAL;
         target_ff <= TGT_NONE;
         cnt_ff    <= 10'd0;
         angle_ff  <= MID_C;
         dir_ff    <= DIR_NEG;
         saved_ff  <= DIR_ZERO;
      end else begin
         phase_ff  <= phase_in;
         target_ff <= target_in;
         cnt_ff    <= cnt_in;
         angle_ff  <= angle_in;
         dir_ff    <= dir_in;
         saved_ff  <= saved_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/swoc_lerp.sv @@
`default_nettype none

module swoc_lerp
   import swoc_pkg::*;
#(
   parameter int unsigned DIV = 200
)
(
   input  wire logic        clock,
   input  wire logic        mul_en,
   input  wire logic        div_en,
   input  wire logic [9:0]  t,
   input  wire logic [11:0] a,
   input  wire logic [11:0] b,
   output logic [11:0]      q
);

   // t is clipped to DIV, so the weights fit in DW bits and a*(DIV-t)+b*t < 4096*DIV
   localparam int unsigned DW = $clog2(DIV + 1);
   localparam int unsigned CW = (DW > 10) ? DW : 10;
   localparam int unsigned NW = 12 + DW;
   // exact reciprocal for any numerator below 2**NW
   localparam int unsigned SH = NW + $clog2(DIV);
   localparam longint unsigned RECIP = ((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV);
   localparam int unsigned RW = $clog2(RECIP + 1);
   localparam logic [CW-1:0] DIV_C   = CW'(DIV);
   localparam logic [RW-1:0] RECIP_C = RW'(RECIP);

   logic [CW-1:0]    t_ext;
   logic [CW-1:0]    t_clip;
   logic [DW-1:0]    w_b;
   logic [DW-1:0]    w_a;
   logic [NW-1:0]    num_in,  num_ff;
   logic [NW+RW-1:0] prod;
   logic [11:0]      q_in,    q_ff;

   assign t_ext  = CW'(t);
   assign t_clip = (t_ext >= DIV_C) ? DIV_C : t_ext;
   assign w_b    = DW'(t_clip);
   assign w_a    = DW'(DIV_C - t_clip);
   assign num_in = NW'(a) * NW'(w_a) + NW'(b) * NW'(w_b);

   assign prod = (NW+RW)'(num_ff) * (NW+RW)'(RECIP_C);
   assign q_in = 12'(prod >> SH);
   assign q    = q_ff;

   always_ff @(posedge clock) begin
      if (mul_en) begin
         num_ff <= num_in;
      end
      if (div_en) begin
         q_ff <= q_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/servo_wing_open_close_sequencer.sv @@
`default_nettype none

// Wing open/close sequencer for a span servo and a turn servo.
// req channel: one transaction per request, either a 10 ms tick carrying the
//   end-switch level, an open/close target, or scan on/off. Mode three is
//   accepted and only reports the current pulses.
// rsp channel: exactly one transaction per request, in order, carrying both
//   pulse widths, the phase and the open flag after that request.
// csr port: seven 32-bit registers at byte addresses 0, 4 .. 24; write only
//   while no request is in flight. pready is tied high.
// Pipeline: a request passes the control update, ramp products, reciprocal
//   multiply and output registers in that order on its way to rsp.
// Throughput: one request per cycle while req_stall is low. The control state is updated in the
//   accept cycle; the ramp arithmetic behind it needs no feedback.
// Stall: every stage empties into the next while rsp is stalled, so up to four
//   transactions are held before req_stall rises.
// Reset: synchronous, clears the pipeline, restores register defaults, and the
//   first tick afterwards makes the start-up decision from the end switch.
module servo_wing_open_close_sequencer
   import swoc_pkg::*;
#(
   parameter int unsigned TURN_RANGE = 128,
   parameter int unsigned RAMP_TICKS = 200
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   cfg_type     cfg;
   step_type    step;
   logic        accept;

   // stage enables: a stage loads when it is empty or its content moves on
   logic        take1, take2, take3, take4;
   logic        v1_ff, v2_ff, v3_ff;
   step_type    s1_ff;
   tag_type     s2_ff, s3_ff;
   tag_type     s1_tag;
   logic [11:0] span_q, turn_q;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff, rsp_in;

   assign take4  = !rsp_valid_ff || !rsp_stall;
   assign take3  = !v3_ff || take4;
   assign take2  = !v2_ff || take3;
   assign take1  = !v1_ff || take2;
   assign req_stall = !take1;
   assign accept = req_valid && take1;

   swoc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   swoc_ctrl #(
      .TURN_RANGE (TURN_RANGE)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .cfg    (cfg),
      .step   (step)
   );

   // span ramp between the configured widths over RAMP_TICKS
   swoc_lerp #(
      .DIV (RAMP_TICKS)
   ) u_span_lerp (
      .clock  (clock),
      .mul_en (take2),
      .div_en (take3),
      .t      (s1_ff.span.t),
      .a      (s1_ff.span.a),
      .b      (s1_ff.span.b),
      .q      (span_q)
   );

   // turn angle mapped onto the turn pulse range
   swoc_lerp #(
      .DIV (TURN_RANGE)
   ) u_turn_lerp (
      .clock  (clock),
      .mul_en (take2),
      .div_en (take3),
      .t      (s1_ff.turn.t),
      .a      (s1_ff.turn.a),
      .b      (s1_ff.turn.b),
      .q      (turn_q)
   );

   assign s1_tag.phase     = s1_ff.phase;
   assign s1_tag.span_load = s1_ff.span.load;
   assign s1_tag.turn_load = s1_ff.turn.load;

   // output merge: a pulse not touched by the transaction keeps its last value
   always_comb begin
      rsp_in               = rsp_ff;
      rsp_in.phase         = s3_ff.phase;
      rsp_in.is_open       = (s3_ff.phase == PH_OPEN);
      if (s3_ff.span_load) begin
         rsp_in.span_pulse_us = span_q;
      end
      if (s3_ff.turn_load) begin
         rsp_in.turn_pulse_us = turn_q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take1) begin
            v1_ff <= accept;
         end
         if (take2) begin
            v2_ff <= v1_ff;
         end
         if (take3) begin
            v3_ff <= v2_ff;
         end
         if (take4) begin
            rsp_valid_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take1) begin
         s1_ff <= step;
      end
      if (take2) begin
         s2_ff <= s1_tag;
      end
      if (take3) begin
         s3_ff <= s2_ff;
      end
   end

   // last reported pulses double as the held servo state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.span_pulse_us <= 12'd0;
         rsp_ff.turn_pulse_us <= TURN_RESET_US;
         rsp_ff.phase         <= PH_INITIAL;
         rsp_ff.is_open       <= 1'b0;
      end else if (take4 && v3_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a broken mechanism reports both servos off
   a_broken_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.phase == PH_BROKEN) |->
         (rsp_data.span_pulse_us == 12'd0 && rsp_data.turn_pulse_us == 12'd0))
      else $error("broken phase with a live servo pulse");

   // broken is terminal
   a_broken_sticks: assert property (@(posedge clock) disable iff (reset)
      (rsp_data.phase == PH_BROKEN) |=> (rsp_data.phase == PH_BROKEN))
      else $error("left the broken phase");

   // requests are held off only when every stage is full and rsp is stalled
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && v1_ff && v2_ff && v3_ff))
      else $error("request stalled with room in the pipeline");

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import swoc_pkg::*;

   // mode code the block accepts but does nothing with
   localparam logic [1:0] MODE_IGNORED = 2'd3;

   // tracks the wing sequencer state and the pulse transactions still owed
   class wing_pulse_tracker;
      localparam int SWEEP_RANGE = 128;
      localparam int RAMP_STEPS  = 200;

      cfg_type     cfg;
      logic [2:0]  phase;
      logic [1:0]  target;
      int unsigned ramp;
      int          angle;
      int          dir;
      int          saved_dir;
      logic [11:0] span;
      logic [11:0] turn;
      rsp_type     pending_pulses[$];
      int          errors;
      int          checked;
      logic [7:0]  phases_seen;

      function new();
         cfg.open_start_us       = RST_OPEN_START_US;
         cfg.open_end_us         = RST_OPEN_END_US;
         cfg.close_start_us      = RST_CLOSE_START_US;
         cfg.close_end_us        = RST_CLOSE_END_US;
         cfg.opening_ticks       = RST_OPENING_TICKS;
         cfg.opening_dead_ticks  = RST_DEAD_TICKS;
         cfg.close_timeout_ticks = RST_CLOSE_TIMEOUT;
         phase       = PH_INITIAL;
         target      = TGT_NONE;
         ramp        = 0;
         angle       = SWEEP_RANGE / 2;
         dir         = -1;
         saved_dir   = 0;
         span        = '0;
         turn        = TURN_RESET_US;
         errors      = 0;
         checked     = 0;
         phases_seen = '0;
      endfunction

      // linear ramp from a to b over dt steps, truncated, end value once t reaches dt
      function logic [11:0] ramp_us(int unsigned t, int unsigned dt,
                                    logic [11:0] a, logic [11:0] b);
         longint unsigned la;
         longint unsigned lb;
         longint unsigned acc;
         la = a;
         lb = b;
         if (dt == 0 || t >= dt) begin
            return b;
         end
         acc = la * (dt - t) + lb * t;
         return 12'(acc / dt);
      endfunction

      function void set_turn();
         turn = ramp_us(angle, SWEEP_RANGE, TURN_MIN_US, TURN_MAX_US);
      endfunction

      function void enter_broken();
         phase = PH_BROKEN;
         span  = '0;
         turn  = '0;
      endfunction

      function void start_close(logic sw);
         if (sw) begin
            phase = PH_CLOSED;
         end else if (phase == PH_OPEN) begin
            phase = PH_CENTERING;
            span  = '0;
            set_turn();
         end else begin
            phase = PH_CLOSING;
            span  = cfg.close_start_us;
            ramp  = 0;
         end
      endfunction

      function void advance(logic sw);
         int unsigned n;
         int          mid;
         mid = SWEEP_RANGE / 2;
         case (phase)
            PH_INITIAL: begin
               start_close(sw);
            end
            PH_OPENING: begin
               ramp = (ramp < CNT_MAX) ? ramp + 1 : CNT_MAX;
               span = ramp_us(ramp, RAMP_STEPS, cfg.open_start_us, cfg.open_end_us);
               if (target == TGT_CLOSED) begin
                  start_close(sw);
               end else if (ramp >= cfg.opening_dead_ticks && sw) begin
                  enter_broken();
               end else if (ramp >= cfg.opening_ticks) begin
                  phase = PH_OPEN;
                  span  = '0;
               end
            end
            PH_OPEN: begin
               if (target == TGT_CLOSED) begin
                  start_close(sw);
               end else if (dir != 0) begin
                  angle += dir;
                  if (angle < 0) begin
                     angle = 0;
                     dir   = 1;
                  end else if (angle > SWEEP_RANGE) begin
                     angle = SWEEP_RANGE;
                     dir   = -1;
                  end
                  set_turn();
               end
            end
            PH_CENTERING: begin
               if (target == TGT_OPEN) begin
                  phase = PH_OPEN;
               end else if (angle == mid) begin
                  phase = PH_CLOSING;
                  span  = cfg.close_start_us;
                  ramp  = 0;
               end else begin
                  angle = (angle > mid) ? angle - 1 : angle + 1;
                  set_turn();
               end
            end
            PH_CLOSING: begin
               ramp = (ramp < CNT_MAX) ? ramp + 1 : CNT_MAX;
               span = ramp_us(ramp, RAMP_STEPS, cfg.close_start_us, cfg.close_end_us);
               if (sw) begin
                  phase = PH_CLOSED;
                  span  = '0;
               end else begin
                  // second count step per tick, timeout judged before clipping
                  n    = ramp + 1;
                  ramp = (n > CNT_MAX) ? CNT_MAX : n;
                  if (n > cfg.close_timeout_ticks) begin
                     enter_broken();
                  end
               end
            end
            PH_CLOSED: begin
               if (target == TGT_OPEN) begin
                  phase = PH_OPENING;
                  span  = cfg.open_start_us;
                  ramp  = 0;
               end
            end
            default: begin
            end
         endcase
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] value);
         case (idx)
            REG_OPEN_START:    cfg.open_start_us       = value[11:0];
            REG_OPEN_END:      cfg.open_end_us         = value[11:0];
            REG_CLOSE_START:   cfg.close_start_us      = value[11:0];
            REG_CLOSE_END:     cfg.close_end_us        = value[11:0];
            REG_OPENING_TICKS: cfg.opening_ticks       = value[9:0];
            REG_DEAD_TICKS:    cfg.opening_dead_ticks  = value[9:0];
            REG_CLOSE_TIMEOUT: cfg.close_timeout_ticks = value[9:0];
            default: begin
            end
         endcase
      endfunction

      // an accepted request: update the state and queue the pulses it yields
      function void note_request(req_type r);
         rsp_type want;
         case (r.mode)
            MODE_TICK: begin
               advance(r.switch_closed);
            end
            MODE_TARGET: begin
               target = r.request_value ? TGT_OPEN : TGT_CLOSED;
            end
            MODE_SCAN: begin
               if (r.request_value) begin
                  dir = (saved_dir == 0) ? 1 : saved_dir;
               end else begin
                  saved_dir = dir;
                  dir       = 0;
               end
            end
            default: begin
            end
         endcase
         want.span_pulse_us = span;
         want.turn_pulse_us = turn;
         want.phase         = phase;
         want.is_open       = (phase == PH_OPEN);
         phases_seen[phase] = 1'b1;
         pending_pulses.push_back(want);
      endfunction

      function void compare_field(string name, logic [11:0] want, logic [11:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      function void check_pulses(rsp_type got);
         rsp_type want;
         if (pending_pulses.size() == 0) begin
            errors++;
            $display("%0t: result with nothing expected: %p", $time, got);
            return;
         end
         want = pending_pulses.pop_front();
         checked++;
         compare_field("span_pulse_us", want.span_pulse_us, got.span_pulse_us);
         compare_field("turn_pulse_us", want.turn_pulse_us, got.turn_pulse_us);
         compare_field("phase", want.phase, got.phase);
         compare_field("is_open", want.is_open, got.is_open);
      endfunction
   endclass

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [31:0]           pwdata    = '0;
   logic [31:0]           prdata;
   logic                  pready;

   wing_pulse_tracker tr;

   // stimulus mix in percent: target requests, of those open, scan requests, switch closed
   int tgt_pct;
   int open_pct;
   int scan_pct;
   int sw_pct;
   int sent       = 0;
   int csr_writes = 0;
   bit tx_burst   = 1'b0;
   bit rx_burst   = 1'b0;
   int stall_left = 0;

   servo_wing_open_close_sequencer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // result side: check each transaction, then hold stall at random, never in a burst
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         tr.check_pulses(rsp_data);
         if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
         stall_left = rx_burst ? 0 : $urandom_range(0, 9);
      end
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic req_type make_req(logic [1:0] m, logic sw, logic v);
      req_type r;
      r.mode          = m;
      r.switch_closed = sw;
      r.request_value = v;
      return r;
   endfunction

   // random request shaped by the current mix; ticks steer clear of a breakdown
   function automatic req_type pick_request();
      req_type     r;
      int unsigned roll;
      int unsigned next_cnt;
      roll            = $urandom_range(0, 99);
      r.switch_closed = ($urandom_range(0, 99) < sw_pct);
      r.request_value = 1'($urandom_range(0, 1));
      if (roll < tgt_pct) begin
         r.mode          = MODE_TARGET;
         r.request_value = ($urandom_range(0, 99) < open_pct);
      end else if (roll < tgt_pct + scan_pct) begin
         r.mode          = MODE_SCAN;
         r.request_value = ($urandom_range(0, 99) < 70);
      end else if (roll < tgt_pct + scan_pct + 3) begin
         r.mode = MODE_IGNORED;
      end else begin
         r.mode   = MODE_TICK;
         next_cnt = (tr.ramp < CNT_MAX) ? tr.ramp + 1 : CNT_MAX;
         // a closed switch late in opening would break the mechanism for good
         if (tr.phase == PH_OPENING && tr.target != TGT_CLOSED
             && next_cnt >= tr.cfg.opening_dead_ticks) begin
            r.switch_closed = 1'b0;
         end
         // likewise a closing run that is about to time out gets its switch
         if (tr.phase == PH_CLOSING && next_cnt + 1 > tr.cfg.close_timeout_ticks) begin
            r.switch_closed = 1'b1;
         end
      end
      return r;
   endfunction

   // one input transaction after a random gap; noted once the block takes it
   task automatic send_request(input req_type r);
      int unsigned gap;
      if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
      gap = tx_burst ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      tr.note_request(r);
      sent++;
   endtask

   // stop sending until every owed transaction has come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (tr.pending_pulses.size() != 0);
   endtask

   // register write, then a read back of the same register
   task automatic write_csr(input logic [2:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      tr.write_reg(idx, value);
      csr_writes++;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== value) begin
         tr.errors++;
         $display("%0t: register %0d read expected %0d, got %0d", $time, idx, value, prdata);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic program_regs(input cfg_type c);
      write_csr(REG_OPEN_START, 32'(c.open_start_us));
      write_csr(REG_OPEN_END, 32'(c.open_end_us));
      write_csr(REG_CLOSE_START, 32'(c.close_start_us));
      write_csr(REG_CLOSE_END, 32'(c.close_end_us));
      write_csr(REG_OPENING_TICKS, 32'(c.opening_ticks));
      write_csr(REG_DEAD_TICKS, 32'(c.opening_dead_ticks));
      write_csr(REG_CLOSE_TIMEOUT, 32'(c.close_timeout_ticks));
   endtask

   // random traffic with one full drain halfway through
   task automatic run_phase(input int count);
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) drain();
         send_request(pick_request());
      end
   endtask

   initial begin
      cfg_type c;
      req_type r;
      tr = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: reset values, scan toggling and the start-up decision
      send_request(make_req(MODE_IGNORED, 1'b0, 1'b0));
      send_request(make_req(MODE_SCAN, 1'b0, 1'b1));  // zero saved direction becomes +1
      send_request(make_req(MODE_SCAN, 1'b0, 1'b0));
      send_request(make_req(MODE_SCAN, 1'b0, 1'b1));  // reload of the saved direction
      send_request(make_req(MODE_TICK, 1'b0, 1'b0));  // start-up with switch open: closing
      send_request(make_req(MODE_TICK, 1'b0, 1'b0));
      send_request(make_req(MODE_TICK, 1'b1, 1'b0));  // switch trips: closed
      send_request(make_req(MODE_TARGET, 1'b0, 1'b1));
      send_request(make_req(MODE_TICK, 1'b0, 1'b0));  // closed to opening
      send_request(make_req(MODE_TICK, 1'b0, 1'b0));
      send_request(make_req(MODE_TICK, 1'b0, 1'b0));
      send_request(make_req(MODE_TARGET, 1'b0, 1'b0));
      send_request(make_req(MODE_TICK, 1'b1, 1'b0));  // close while opening, switch closed
      send_request(make_req(MODE_TARGET, 1'b1, 1'b1));
      send_request(make_req(MODE_TICK, 1'b1, 1'b1));
      send_request(make_req(MODE_TARGET, 1'b0, 1'b0));
      send_request(make_req(MODE_TICK, 1'b0, 1'b1));  // close while opening, switch open
      send_request(make_req(MODE_TICK, 1'b1, 1'b0));
      send_request(make_req(MODE_IGNORED, 1'b1, 1'b1));
      drain();

      // pulse extremes, shortest opening, dead window from the first tick, tightest timeout
      program_regs('{12'd0, 12'd4095, 12'd4095, 12'd0, 10'd1, 10'd0, 10'd1});
      tgt_pct = 20; open_pct = 50; scan_pct = 8; sw_pct = 30;
      run_phase(30);
      drain();

      // reversed extremes with all three windows set to 1000
      program_regs('{12'd4095, 12'd0, 12'd0, 12'd4095, 10'd1000, 10'd1000, 10'd1000});
      run_phase(40);

      // random settings with short opening and moderate timeout
      for (int k = 0; k < 2; k++) begin
         drain();
         c.open_start_us       = 12'($urandom_range(0, 4095));
         c.open_end_us         = 12'($urandom_range(0, 4095));
         c.close_start_us      = 12'($urandom_range(0, 4095));
         c.close_end_us        = 12'($urandom_range(0, 4095));
         c.opening_ticks       = 10'($urandom_range(2, 20));
         c.opening_dead_ticks  = 10'($urandom_range(0, c.opening_ticks));
         c.close_timeout_ticks = 10'($urandom_range(30, 80));
         program_regs(c);
         tgt_pct = 15; open_pct = 60; scan_pct = 10; sw_pct = 20;
         run_phase(40);
      end

      // mostly open with scanning so the sweep reaches an end and turns; zero opening ticks
      drain();
      c.open_start_us       = 12'($urandom_range(0, 4095));
      c.open_end_us         = 12'($urandom_range(0, 4095));
      c.opening_ticks       = 10'd0;
      c.opening_dead_ticks  = 10'd1;
      c.close_timeout_ticks = 10'd1000;
      program_regs(c);
      tgt_pct = 3; open_pct = 90; scan_pct = 4; sw_pct = 10;
      run_phase(100);

      // widest timeout: keep closing with the switch open until the mechanism breaks
      drain();
      c.close_start_us      = 12'($urandom_range(0, 4095));
      c.close_end_us        = 12'($urandom_range(0, 4095));
      c.opening_ticks       = 10'd1;
      c.opening_dead_ticks  = 10'd1023;
      c.close_timeout_ticks = 10'd1023;
      program_regs(c);
      for (int k = 0; k < 3000 && tr.phase != PH_BROKEN; k++) begin
         if (tr.phase == PH_CLOSED && tr.target != TGT_OPEN) begin
            r = make_req(MODE_TARGET, 1'b0, 1'b1);
         end else if ((tr.phase == PH_OPENING || tr.phase == PH_OPEN)
                      && tr.target != TGT_CLOSED) begin
            r = make_req(MODE_TARGET, 1'b0, 1'b0);
         end else begin
            r = make_req(MODE_TICK, 1'b0, 1'($urandom_range(0, 1)));
         end
         send_request(r);
      end

      // broken for good: everything that follows must leave the pulses off
      tgt_pct = 20; open_pct = 50; scan_pct = 20; sw_pct = 50;
      run_phase(20);

      drain();
      repeat (8) @(posedge clock);
      $display("%0d requests sent, %0d results checked, %0d register writes",
               sent, tr.checked, csr_writes);
      $display("phases reached (bit per phase, broken highest): %b", tr.phases_seen[6:0]);
      if (tr.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // watchdog
   initial begin
      #400000;
      $display("timeout with %0d results outstanding", tr.pending_pulses.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule
